// ----- sv/fore_pkg.sv -----
// Shared types, constants and helpers for the frame-of-reference block encoder.
// No dependencies; fore_emit and the top level in sv/ use it by scoped names.
package fore_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BW_W    = 6;
  localparam int unsigned CFG_W   = 6;

  localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = 6'd32;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIFF,
    ST_FLS,
    ST_HEAD,
    ST_READ,
    ST_SEND
  } fore_state_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic [BW_W-1:0]    bit_width;
    logic               last;
  } fore_res_t;

  // Find-last-set: position of the highest set bit, LSB at 1, 0 for zero.
  function automatic logic [BW_W-1:0] fls(input logic [VALUE_W-1:0] v);
    logic [BW_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (v[i]) begin
        pos = BW_W'(i + 1);
      end
    end
    return pos;
  endfunction

endpackage

// ----- sv/fore_sample_ram.sv -----
// Sample store of the encoder: one write port, one read port, registered read.
// Depends on nothing; instantiated by frame_of_reference_block_encoder.
module fore_sample_ram #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/fore_emit.sv -----
// Result output register of the encoder: holds one result until its transfer.
// Depends on fore_pkg; instantiated by frame_of_reference_block_encoder.
module fore_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  fore_pkg::fore_res_t  res,
  output logic                 free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,   // [31:0] value, [37:32] bit_width, [39:38] zero
  output logic                 out_tuser,   // [0] kind
  output logic                 out_tlast
);

  logic                valid_r;
  fore_pkg::fore_res_t res_r;

  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, res_r.bit_width, res_r.value};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

endmodule

// ----- sv/frame_of_reference_block_encoder.sv -----
// Top level of the frame-of-reference block encoder: load sequencer, block statistics
// and drain sequencer. Depends on fore_pkg, fore_sample_ram and fore_emit.
//
//  channel | ports                          | payload
//  --------+--------------------------------+--------------------------------------------
//  in      | in_tvalid/in_tready            | tdata[31:0] sample, tlast end_of_data
//  out     | out_tvalid/out_tready          | tdata[31:0] value, [37:32] bit_width,
//          |                                | tuser kind, tlast block_last
//  cfg     | cfg_valid/cfg_ready            | cfg_data[5:0] block_size
//
// Samples that do not close a block are accepted back to back while loading. A closing
// sample is followed by a difference step, a bit width step, the header and the slots;
// each slot reads the single read port of the sample store and then loads the output
// register. Input is held off while a block drains; the last result may still wait.
// Reset clears the block statistics and sets block_size to 32; the store is not cleared.
// cfg is always ready.
module frame_of_reference_block_encoder #(
  parameter int unsigned MAX_BLOCK   = 32,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] value, [37:32] bit_width, [39:38] zero
  output logic        out_tuser,   // [0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data     // [5:0] block_size
);

  localparam int unsigned ADDR_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK + 1);

  fore_pkg::fore_state_t state_r, state_nxt;

  logic [fore_pkg::CFG_W-1:0] block_size_r;
  logic [CNT_W-1:0]           fill_r;
  logic [CNT_W-1:0]           slots_r;
  logic [CNT_W-1:0]           idx_r;
  logic [SAMPLE_BITS-1:0]     min_r;
  logic [SAMPLE_BITS-1:0]     max_r;
  logic [SAMPLE_BITS-1:0]     diff_r;
  logic [fore_pkg::BW_W-1:0]  width_r;

  logic [SAMPLE_BITS-1:0]     sample;
  logic [SAMPLE_BITS-1:0]     rdata;
  logic [CNT_W-1:0]           size_eff;
  logic [CNT_W-1:0]           fill_inc;
  logic                       in_xfer;
  logic                       close;
  logic                       slot_last;
  logic                       emit_free;
  logic                       emit_load;
  logic                       ram_re;
  fore_pkg::fore_res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= fore_pkg::BLOCK_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      block_size_r <= cfg_data;
    end
  end

  // Zero acts as one, anything above the store depth saturates.
  always_comb begin
    priority if (block_size_r == '0) begin
      size_eff = CNT_W'(1);
    end else if (7'(block_size_r) > 7'(MAX_BLOCK)) begin
      size_eff = CNT_W'(MAX_BLOCK);
    end else begin
      size_eff = CNT_W'(block_size_r);
    end
  end

  assign sample    = in_tdata[SAMPLE_BITS-1:0];
  assign in_xfer   = in_tvalid && in_tready;
  assign fill_inc  = fill_r + CNT_W'(1);
  assign close     = in_tlast || (fill_inc >= size_eff);
  assign slot_last = (idx_r + CNT_W'(1)) == slots_r;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fore_pkg::ST_LOAD: begin
        if (in_xfer && close) begin
          state_nxt = fore_pkg::ST_DIFF;
        end
      end
      fore_pkg::ST_DIFF: state_nxt = fore_pkg::ST_FLS;
      fore_pkg::ST_FLS:  state_nxt = fore_pkg::ST_HEAD;
      fore_pkg::ST_HEAD: begin
        if (emit_free) begin
          state_nxt = fore_pkg::ST_READ;
        end
      end
      fore_pkg::ST_READ: state_nxt = fore_pkg::ST_SEND;
      fore_pkg::ST_SEND: begin
        if (emit_free) begin
          state_nxt = slot_last ? fore_pkg::ST_LOAD : fore_pkg::ST_READ;
        end
      end
      default: state_nxt = fore_pkg::ST_LOAD;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_tready     = 1'b0;
    ram_re        = 1'b0;
    emit_load     = 1'b0;
    res.kind      = fore_pkg::KIND_SAMPLE;
    res.value     = '0;
    res.bit_width = width_r;
    res.last      = 1'b0;
    unique case (state_r)
      fore_pkg::ST_LOAD: in_tready = 1'b1;
      fore_pkg::ST_DIFF, fore_pkg::ST_FLS: begin
      end
      fore_pkg::ST_HEAD: begin
        emit_load = emit_free;
        res.kind  = fore_pkg::KIND_HEADER;
        res.value = fore_pkg::VALUE_W'(min_r);
      end
      fore_pkg::ST_READ: ram_re = 1'b1;
      fore_pkg::ST_SEND: begin
        emit_load = emit_free;
        res.last  = slot_last;
        // pad slots past the fill with zero
        if (idx_r < fill_r) begin
          res.value = fore_pkg::VALUE_W'(rdata - min_r);
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fore_pkg::ST_LOAD;
      fill_r  <= '0;
      min_r   <= '1;
      max_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        fill_r <= fill_inc;
        if (sample < min_r) begin
          min_r <= sample;
        end
        if (sample > max_r) begin
          max_r <= sample;
        end
      end
      if (state_r == fore_pkg::ST_HEAD) begin
        idx_r <= '0;
      end
      if (state_r == fore_pkg::ST_SEND && emit_free) begin
        idx_r <= idx_r + CNT_W'(1);
        // drop the block statistics after its final slot
        if (slot_last) begin
          fill_r <= '0;
          min_r  <= '1;
          max_r  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fore_pkg::ST_DIFF) begin
      diff_r  <= max_r - min_r;
      slots_r <= (fill_r > size_eff) ? fill_r : size_eff;
    end
    if (state_r == fore_pkg::ST_FLS) begin
      width_r <= fore_pkg::fls(fore_pkg::VALUE_W'(diff_r));
    end
  end

  fore_sample_ram #(
    .DEPTH  (MAX_BLOCK),
    .WIDTH  (SAMPLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (sample),
    .re    (ram_re),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  fore_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit_load),
    .res        (res),
    .free       (emit_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // A loading block always closes before the store overflows.
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> fill_r < CNT_W'(MAX_BLOCK))
    else $error("fill count reached store depth while loading");

  // Once a sample is in, the running minimum never exceeds the running maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && fill_r != '0) |-> min_r <= max_r)
    else $error("running minimum above running maximum");

  // Slots cover every stored sample and never run past the last one.
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fore_pkg::ST_SEND) |-> (idx_r < slots_r && fill_r <= slots_r))
    else $error("slot index outside the block");

  // A header is never the final result of a block.
  a_header_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == fore_pkg::KIND_HEADER) |-> !out_tlast)
    else $error("header marked as last result");

  // After the final slot transfer the block is ready to load again.
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fore_pkg::ST_SEND && emit_free && slot_last) |=>
      (in_tready && fill_r == '0))
    else $error("block did not return to loading after its last slot");
`endif

endmodule

// ----- dv/tb_frame_of_reference_block_encoder.sv -----
// Self-checking testbench for frame_of_reference_block_encoder: a scoreboard class predicts
// header and normalized-sample transfers per closed block. Depends on fore_pkg and the RTL.
module tb_frame_of_reference_block_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLOCK_CAP = 32;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [7:0]  RX_PATTERN = 8'b1011_0011;

  class fore_block_encoding;
    logic [31:0]        stored [BLOCK_CAP];
    int unsigned        fill;
    logic [31:0]        lo_val;
    logic [31:0]        hi_val;
    logic [5:0]         size_reg;
    fore_pkg::fore_res_t due_results [$];
    int unsigned        mismatches;

    function new();
      size_reg   = fore_pkg::BLOCK_SIZE_RST;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      fill   = 0;
      lo_val = '1;
      hi_val = '0;
    endfunction

    function void set_block_size(logic [5:0] v);
      size_reg = v;
    endfunction

    function void append_result(fore_pkg::fore_res_t r);
      due_results.insert(due_results.size(), r);
    endfunction

    // Take one accepted sample; on block close queue the header and every slot.
    function void take_sample(logic [31:0] s, logic eod);
      int unsigned         size;
      int unsigned         slots;
      int unsigned         width;
      logic [31:0]         span;
      fore_pkg::fore_res_t r;
      size = (size_reg == 0) ? 1 : ((size_reg > BLOCK_CAP) ? BLOCK_CAP : size_reg);
      if (fill < BLOCK_CAP) begin
        stored[fill] = s;
        fill++;
      end
      if (s < lo_val) lo_val = s;
      if (s > hi_val) hi_val = s;
      if (!eod && fill < size) return;
      // lowered size keeps every stored sample, no padding
      slots = (fill > size) ? fill : size;
      span  = hi_val - lo_val;
      width = 0;
      while (span != 0) begin
        width++;
        span = span >> 1;
      end
      r.kind      = fore_pkg::KIND_HEADER;
      r.value     = lo_val;
      r.bit_width = width[5:0];
      r.last      = 1'b0;
      append_result(r);
      for (int unsigned i = 0; i < slots; i++) begin
        r.kind  = fore_pkg::KIND_SAMPLE;
        r.value = (i < fill) ? stored[i] - lo_val : 32'd0;
        r.last  = (i + 1 == slots);
        append_result(r);
      end
      restart();
    endfunction

    function void match_result(fore_pkg::fore_res_t got);
      fore_pkg::fore_res_t exp_r;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: kind=%0d value=%h width=%0d last=%0d",
                   got.kind, got.value, got.bit_width, got.last);
        return;
      end
      exp_r = due_results.pop_front();
      if (got.kind !== exp_r.kind || got.value !== exp_r.value ||
          got.bit_width !== exp_r.bit_width || got.last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result differs: exp kind=%0d value=%h width=%0d last=%0d",
                   exp_r.kind, exp_r.value, exp_r.bit_width, exp_r.last);
          $display("                got kind=%0d value=%h width=%0d last=%0d",
                   got.kind, got.value, got.bit_width, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  fore_block_encoding sb = new();

  int unsigned rx_mode = 0;
  int unsigned long_hold_req = 0;
  int unsigned long_hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_phase = 0;
  int unsigned sent_total = 0;

  frame_of_reference_block_encoder #(
    .MAX_BLOCK  (BLOCK_CAP),
    .SAMPLE_BITS(32)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Observe every transfer at the rising edge.
  always @(posedge clk) begin
    fore_pkg::fore_res_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_block_size(cfg_data);
      if (in_tvalid && in_tready) sb.take_sample(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.kind      = out_tuser;
        got.value     = out_tdata[31:0];
        got.bit_width = out_tdata[37:32];
        got.last      = out_tlast;
        sb.match_result(got);
      end
    end
  end

  // Receiver: a long hold on request, otherwise the current stall pattern.
  always @(negedge clk) begin
    rx_phase++;
    if (hold_left != 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else if (long_hold_req != long_hold_seen) begin
      long_hold_seen = long_hold_req;
      hold_left      = 299;
      out_tready     = 1'b0;
    end else begin
      case (rx_mode)
        0:       out_tready = 1'b1;
        1:       out_tready = ($urandom_range(0, 3) != 0);
        default: out_tready = RX_PATTERN[rx_phase[2:0]];
      endcase
    end
  end

  task automatic send_sample(logic [31:0] s, logic eod);
    in_tvalid = 1'b1;
    in_tdata  = s;
    in_tlast  = eod;
    do @(posedge clk); while (!in_tready);
    sent_total++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int unsigned n);
    in_tvalid = 1'b0;
    in_tdata  = $urandom;
    in_tlast  = 1'($urandom_range(0, 1));
    repeat (n) @(negedge clk);
  endtask

  // Wait out every queued result, then let a non-closing sample settle.
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_block_size(logic [5:0] v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_sample(logic [31:0] base, int unsigned spread);
    logic [63:0] m;
    m = (64'd1 << spread) - 64'd1;
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'd0;
      2:       return 32'hFFFF_FFFF;
      default: return base + ($urandom & m[31:0]);
    endcase
  endfunction

  task automatic run_phase(int unsigned n_items, bit back_to_back);
    int unsigned left;
    int unsigned burst;
    int unsigned spread;
    logic [31:0] base;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      base   = $urandom;
      spread = $urandom_range(0, 32);
      repeat (burst) send_sample(pick_sample(base, spread), $urandom_range(0, 9) == 0);
      left -= burst;
      if (!back_to_back && $urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
    end
  endtask

  initial begin
    int unsigned phase_no;
    logic [5:0]  next_size;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset block size: one short block padded out to all slots
    send_sample(32'd3, 1'b0);
    send_sample(32'd9, 1'b1);
    wait_drained();
    // smallest block, extreme values
    write_block_size(6'd1);
    send_sample(32'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    wait_drained();
    // zero size behaves as one
    write_block_size(6'd0);
    send_sample(32'hA5A5_A5A5, 1'b0);
    wait_drained();
    // full width span, equal samples with padding, lone end-of-data sample
    write_block_size(6'd4);
    send_sample(32'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'd2, 1'b0);
    send_sample(32'd7, 1'b0);
    send_sample(32'd7, 1'b1);
    send_sample(32'd5, 1'b1);
    wait_drained();
    // shrink size below the current fill: next sample closes with no padding
    write_block_size(6'd6);
    send_sample(32'd100, 1'b0);
    send_sample(32'd90, 1'b0);
    send_sample(32'd120, 1'b0);
    send_sample(32'd95, 1'b0);
    wait_drained();
    write_block_size(6'd2);
    send_sample(32'd80, 1'b0);
    wait_drained();
    // oversize saturates to the store depth
    write_block_size(6'd63);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h5555_AAAA, 1'b1);

    phase_no = 0;
    while (sent_total < 270) begin
      wait_drained();
      if (phase_no == 1) begin
        // stall the output long enough for the input to back up
        write_block_size(6'd32);
        rx_mode = 1;
        long_hold_req++;
        run_phase(64, 1'b1);
      end else begin
        case ($urandom_range(0, 7))
          0:       next_size = 6'd1;
          1:       next_size = 6'd0;
          2:       next_size = 6'd32;
          3:       next_size = 6'd63;
          4:       next_size = 6'($urandom_range(2, 8));
          5:       next_size = 6'($urandom_range(9, 31));
          6:       next_size = 6'($urandom_range(33, 62));
          default: next_size = 6'($urandom_range(2, 6));
        endcase
        write_block_size(next_size);
        rx_mode = $urandom_range(0, 2);
        run_phase($urandom_range(8, 30), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0) begin
          wait_drained();
          run_phase($urandom_range(4, 12), 1'b0);
        end
      end
      phase_no++;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0)
      $display("frame_of_reference_block_encoder: match");
    else
      $display("frame_of_reference_block_encoder: mismatch");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("frame_of_reference_block_encoder: mismatch");
    $finish;
  end

endmodule

// ----- frame_of_reference_block_encoder.f -----
sv/fore_pkg.sv
sv/fore_sample_ram.sv
sv/fore_emit.sv
sv/frame_of_reference_block_encoder.sv
dv/tb_frame_of_reference_block_encoder.sv
